// ===== rtl/core/rational_accumulator_alu_assert.svh =====
// assertion macros for the rational accumulator alu checker
// no dependencies
`ifndef RATIONAL_ACCUMULATOR_ALU_ASSERT_SVH
`define RATIONAL_ACCUMULATOR_ALU_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define RA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define RA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/ralu_pkg.sv =====
// package for the rational accumulator alu: modes, status codes, command types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ralu_pkg;
    localparam logic [2:0] MODE_LOAD = 3'd0;
    localparam logic [2:0] MODE_ADD  = 3'd1;
    localparam logic [2:0] MODE_SUB  = 3'd2;
    localparam logic [2:0] MODE_MUL  = 3'd3;
    localparam logic [2:0] MODE_DIV  = 3'd4;
    localparam logic [2:0] MODE_CMP  = 3'd5;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_DIV0 = 2'd1;
    localparam logic [1:0] STATUS_OVF  = 2'd2;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LATCH  = 4'd1,
        OP_MUL    = 4'd2,
        OP_COMB   = 4'd3,
        OP_GSTART = 4'd4,
        OP_GSTEP  = 4'd5,
        OP_DSTART = 4'd6,
        OP_DSTEP  = 4'd7,
        OP_COMMIT = 4'd8
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] sel;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic gcd_done;
        logic div_done;
    } stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/ralu_ctrl.sv =====
// controller state machine of the rational accumulator alu
// depends on ralu_pkg
`timescale 1ns / 1ps
`default_nettype none
module ralu_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_fire,
    input  wire logic           out_fire,
    input  wire logic           out_busy,
    input  wire ralu_pkg::stat_t stat,
    output ralu_pkg::cmd_t      cmd,
    output logic                idle
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_MUL   = 8'b00000010,
        S_MWAIT = 8'b00000100,
        S_COMB  = 8'b00001000,
        S_GCD   = 8'b00010000,
        S_DIV   = 8'b00100000,
        S_DWAIT = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] sel_reg, sel_next;

    // a waiting result does not block the input, only the next commit
    assign idle = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd.op     = ralu_pkg::OP_NONE;
        cmd.sel    = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.op     = ralu_pkg::OP_LATCH;
                    sel_next   = 2'd0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // three products, one shared multiplier
                cmd.op     = ralu_pkg::OP_MUL;
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (stat.mul_done)
                begin
                    if (sel_reg == 2'd2)
                        state_next = S_COMB;
                    else
                    begin
                        sel_next   = sel_reg + 2'd1;
                        state_next = S_MUL;
                    end
                end
            end
            S_COMB:
            begin
                cmd.op     = ralu_pkg::OP_COMB;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                cmd.op = ralu_pkg::OP_GSTEP;
                if (stat.gcd_done)
                begin
                    sel_next   = 2'd0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op     = ralu_pkg::OP_DSTART;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                cmd.op = ralu_pkg::OP_DSTEP;
                if (stat.div_done)
                begin
                    if (sel_reg == 2'd1)
                        state_next = S_OUT;
                    else
                    begin
                        sel_next   = 2'd1;
                        state_next = S_DIV;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_busy || out_fire)
                begin
                    cmd.op     = ralu_pkg::OP_COMMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/ralu_datapath.sv =====
// datapath of the rational accumulator alu: multiplier, gcd and divider units
// depends on ralu_pkg
`timescale 1ns / 1ps
`default_nettype none
module ralu_datapath
#(
    parameter int WORD_BITS = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ralu_pkg::cmd_t       cmd,
    input  wire logic [2:0]           in_mode,
    input  wire logic [WORD_BITS-1:0] in_qn,
    input  wire logic [WORD_BITS-1:0] in_qd,
    output ralu_pkg::stat_t           stat,
    output logic [WORD_BITS-1:0]      acc_num,
    output logic [WORD_BITS-1:0]      acc_den,
    output logic [2:0]                flags,
    output logic [1:0]                status
);
    localparam int W  = WORD_BITS;
    localparam int W2 = 2 * WORD_BITS;
    localparam int H  = (W + 1) / 2;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0] a_reg, b_reg, qn_reg, qd_reg;
    logic [2:0]   mode_reg;
    logic [W2-1:0] p0_reg, p1_reg, p2_reg;
    logic [W-1:0] n_reg, d_reg;
    logic         ovf_reg;
    logic [2:0]   flags_reg;
    logic [1:0]   status_reg;
    logic [W2-1:0] sum;
    logic [2:0]   cmp_flags;
    logic [1:0]   commit_status;

    // multiplier: magnitude product over four half-width partial products
    logic [W-1:0] mx_reg, my_reg;
    logic         mneg_reg;
    logic [2:0]   mcnt_reg;
    logic         mlast_reg;
    logic [W2-1:0] macc_reg;
    logic [W-1:0] op_x, op_y;
    logic [H-1:0] hx, hy;
    logic [2*H-1:0] pp;
    logic [W2-1:0] pp_sh, mprod;

    // gcd and divider
    logic [W-1:0] gx_reg, gy_reg, g_reg;
    logic [W-1:0] rem_reg, quo_reg, dvd_reg;
    logic [CW-1:0] dcnt_reg;
    logic         gphase_reg, gbusy_reg, dbusy_reg;
    logic [W-1:0] trial_rem;
    logic [W:0]   trial_sub;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    function automatic logic fits(input logic [W2-1:0] v);
        return v[W2-1:W-1] == {(W + 1){v[W-1]}};
    endfunction

    always_comb
    begin
        case (cmd.sel)
            2'd0:
            begin
                op_x = a_reg;
                op_y = (mode_reg == ralu_pkg::MODE_MUL) ? qn_reg : qd_reg;
            end
            2'd1:
            begin
                op_x = (mode_reg == ralu_pkg::MODE_MUL || mode_reg == ralu_pkg::MODE_DIV)
                       ? b_reg : qn_reg;
                op_y = (mode_reg == ralu_pkg::MODE_MUL) ? qd_reg
                       : ((mode_reg == ralu_pkg::MODE_DIV) ? qn_reg : b_reg);
            end
            default:
            begin
                op_x = b_reg;
                op_y = qd_reg;
            end
        endcase
    end

    assign hx = mcnt_reg[1] ? H'(mx_reg >> H) : mx_reg[H-1:0];
    assign hy = mcnt_reg[0] ? H'(my_reg >> H) : my_reg[H-1:0];
    assign pp = (2*H)'(hx) * (2*H)'(hy);
    assign pp_sh = W2'(pp) << ((mcnt_reg[1] ? H : 0) + (mcnt_reg[0] ? H : 0));
    assign mprod = mneg_reg ? (~macc_reg + W2'(1)) : macc_reg;

    assign sum = (mode_reg == ralu_pkg::MODE_SUB) ? p0_reg - p1_reg : p0_reg + p1_reg;

    assign trial_rem = {rem_reg[W-2:0], dvd_reg[W-1]};
    assign trial_sub = {1'b0, trial_rem} - {1'b0, g_reg};

    assign stat.mul_done = (mcnt_reg == 3'd4);
    assign stat.gcd_done = !gbusy_reg && gphase_reg;
    assign stat.div_done = !dbusy_reg && (dcnt_reg == CW'(W));

    // flags and status of the item being committed
    always_comb
    begin
        cmp_flags     = 3'd0;
        commit_status = ralu_pkg::STATUS_OK;
        case (mode_reg)
            ralu_pkg::MODE_ADD, ralu_pkg::MODE_SUB, ralu_pkg::MODE_MUL:
            begin
                if (ovf_reg)
                    commit_status = ralu_pkg::STATUS_OVF;
            end
            ralu_pkg::MODE_DIV:
            begin
                if (qn_reg == '0)
                    commit_status = ralu_pkg::STATUS_DIV0;
                else if (ovf_reg)
                    commit_status = ralu_pkg::STATUS_OVF;
            end
            ralu_pkg::MODE_CMP:
            begin
                // {greater, less, equal}
                if (p0_reg == p1_reg)
                    cmp_flags = 3'b001;
                else if ($signed(p0_reg) < $signed(p1_reg))
                    cmp_flags = 3'b010;
                else
                    cmp_flags = 3'b100;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg      <= '0;
            b_reg      <= W'(1);
            mcnt_reg   <= 3'd4;
            mlast_reg  <= 1'b0;
            gbusy_reg  <= 1'b0;
            gphase_reg <= 1'b0;
            dbusy_reg  <= 1'b0;
            dcnt_reg   <= '0;
            flags_reg  <= 3'd0;
            status_reg <= ralu_pkg::STATUS_OK;
        end
        else
        begin
            mlast_reg <= (mcnt_reg == 3'd3);
            if (mcnt_reg != 3'd4)
            begin
                macc_reg <= macc_reg + pp_sh;
                mcnt_reg <= mcnt_reg + 3'd1;
            end
            case (cmd.op)
                ralu_pkg::OP_LATCH:
                begin
                    mode_reg <= in_mode;
                    qn_reg   <= in_qn;
                    qd_reg   <= in_qd;
                    ovf_reg  <= 1'b0;
                end
                ralu_pkg::OP_MUL:
                begin
                    mx_reg   <= mag(op_x);
                    my_reg   <= mag(op_y);
                    mneg_reg <= op_x[W-1] ^ op_y[W-1];
                    macc_reg <= '0;
                    mcnt_reg <= 3'd0;
                end
                ralu_pkg::OP_COMB:
                begin
                    // p0/p1/p2 hold the three products; build n and d
                    gphase_reg <= 1'b0;
                    gbusy_reg  <= 1'b1;
                    case (mode_reg)
                        ralu_pkg::MODE_ADD, ralu_pkg::MODE_SUB:
                        begin
                            n_reg   <= sum[W-1:0];
                            d_reg   <= p2_reg[W-1:0];
                            ovf_reg <= !fits(p0_reg) || !fits(p1_reg) || !fits(p2_reg)
                                       || !fits(sum);
                        end
                        default:
                        begin
                            n_reg   <= p0_reg[W-1:0];
                            d_reg   <= p1_reg[W-1:0];
                            ovf_reg <= !fits(p0_reg) || !fits(p1_reg);
                        end
                    endcase
                end
                ralu_pkg::OP_GSTEP:
                begin
                    // euclid, each remainder by a bit-serial division
                    if (gbusy_reg && !gphase_reg)
                    begin
                        gx_reg     <= mag(n_reg);
                        gy_reg     <= mag(d_reg);
                        gphase_reg <= 1'b1;
                        dbusy_reg  <= 1'b0;
                    end
                    else if (gbusy_reg)
                    begin
                        if (gy_reg == '0)
                        begin
                            gbusy_reg <= 1'b0;
                            g_reg     <= gx_reg;
                        end
                        else if (!dbusy_reg)
                        begin
                            g_reg     <= gy_reg;
                            dvd_reg   <= gx_reg;
                            rem_reg   <= '0;
                            dcnt_reg  <= '0;
                            dbusy_reg <= 1'b1;
                        end
                        else if (dcnt_reg == CW'(W))
                        begin
                            gx_reg    <= gy_reg;
                            gy_reg    <= rem_reg;
                            dbusy_reg <= 1'b0;
                        end
                        else
                        begin
                            rem_reg  <= trial_sub[W] ? trial_rem : trial_sub[W-1:0];
                            dvd_reg  <= {dvd_reg[W-2:0], 1'b0};
                            dcnt_reg <= dcnt_reg + CW'(1);
                        end
                    end
                end
                ralu_pkg::OP_DSTART:
                begin
                    dvd_reg   <= mag(cmd.sel[0] ? d_reg : n_reg);
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    // zero gcd: no reduction, report done at once
                    dcnt_reg  <= (g_reg == '0) ? CW'(W) : '0;
                    dbusy_reg <= (g_reg != '0);
                end
                ralu_pkg::OP_DSTEP:
                begin
                    if (dbusy_reg)
                    begin
                        if (dcnt_reg == CW'(W))
                        begin
                            dbusy_reg <= 1'b0;
                            if (cmd.sel[0])
                                d_reg <= d_reg[W-1] ? (~quo_reg + W'(1)) : quo_reg;
                            else
                                n_reg <= n_reg[W-1] ? (~quo_reg + W'(1)) : quo_reg;
                        end
                        else
                        begin
                            rem_reg  <= trial_sub[W] ? trial_rem : trial_sub[W-1:0];
                            quo_reg  <= {quo_reg[W-2:0], !trial_sub[W]};
                            dvd_reg  <= {dvd_reg[W-2:0], 1'b0};
                            dcnt_reg <= dcnt_reg + CW'(1);
                        end
                    end
                end
                ralu_pkg::OP_COMMIT:
                begin
                    flags_reg  <= cmp_flags;
                    status_reg <= commit_status;
                    case (mode_reg)
                        ralu_pkg::MODE_LOAD:
                        begin
                            a_reg <= qn_reg;
                            b_reg <= W'(1);
                        end
                        ralu_pkg::MODE_ADD, ralu_pkg::MODE_SUB, ralu_pkg::MODE_MUL:
                        begin
                            a_reg <= n_reg;
                            b_reg <= d_reg;
                        end
                        ralu_pkg::MODE_DIV:
                        begin
                            if (qn_reg != '0)
                            begin
                                a_reg <= n_reg;
                                b_reg <= d_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    // capture each signed product the cycle after its last partial product
    always_ff @(posedge clk)
    begin
        if (mlast_reg)
        begin
            case (cmd.sel)
                2'd0:    p0_reg <= mprod;
                2'd1:    p1_reg <= mprod;
                default: p2_reg <= mprod;
            endcase
        end
    end

    assign acc_num = a_reg;
    assign acc_den = b_reg;
    assign flags   = flags_reg;
    assign status  = status_reg;
endmodule
`default_nettype wire

// ===== rtl/core/rational_accumulator_alu.sv =====
// Rational accumulator alu top level: controller, datapath, output register.
// One item at a time: the next item is accepted from the cycle after commit.
// A result waits in the output register while the next item runs; the next commit
// stalls until that register frees. Reset (rst_n, async active low) sets 0/1.
`timescale 1ns / 1ps
`default_nettype none
module rational_accumulator_alu
#(
    parameter int WORD_BITS = 64
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // mode[2:0], operand_num[66:3], operand_den[130:67], zero pad to 136
    input  wire logic [135:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // result_num[63:0], result_den[127:64], is_equal, is_less, is_greater,
    // status[132:131], zero pad to 136
    output logic [135:0]      m_axis_tdata
);
    ralu_pkg::cmd_t  cmd;
    ralu_pkg::stat_t stat;
    logic idle, in_fire, out_fire, out_busy;
    logic [WORD_BITS-1:0] acc_num, acc_den;
    logic [2:0] flags;
    logic [1:0] status;
    logic ovalid_reg, ovalid_next;
    logic [135:0] odata_reg;
    logic commit_d_reg;

    assign s_axis_tready = idle;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign out_busy = ovalid_reg || commit_d_reg;

    ralu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_fire (out_fire),
        .out_busy (out_busy),
        .stat     (stat),
        .cmd      (cmd),
        .idle     (idle)
    );

    ralu_datapath #(.WORD_BITS(WORD_BITS)) u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_mode (s_axis_tdata[2:0]),
        .in_qn   (s_axis_tdata[3 +: WORD_BITS]),
        .in_qd   (s_axis_tdata[67 +: WORD_BITS]),
        .stat    (stat),
        .acc_num (acc_num),
        .acc_den (acc_den),
        .flags   (flags),
        .status  (status)
    );

    // output register loads the cycle after commit; commit waits on a full register
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (out_fire)
            ovalid_next = 1'b0;
        if (commit_d_reg)
            ovalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg   <= 1'b0;
            commit_d_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg   <= ovalid_next;
            commit_d_reg <= (cmd.op == ralu_pkg::OP_COMMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit_d_reg)
            odata_reg <= {3'd0, status, flags[2], flags[1], flags[0],
                          64'($signed(acc_den)), 64'($signed(acc_num))};
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
endmodule
`default_nettype wire

// ===== rtl/core/ralu_checker.sv =====
// port-level checker for the rational accumulator alu, bound to the top level
// depends on rational_accumulator_alu_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "rational_accumulator_alu_assert.svh"
module ralu_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [135:0] m_axis_tdata
);
    `RA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `RA_ASSERT_NEXT(a_no_back_to_back, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `RA_ASSERT_IMP(a_one_flag, m_axis_tvalid, $countones(m_axis_tdata[130:128]) <= 1)
    `RA_ASSERT_IMP(a_status_code, m_axis_tvalid, m_axis_tdata[132:131] != 2'd3)
endmodule
bind rational_accumulator_alu ralu_checker u_ralu_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
